FILE: hdl/stws_pkg.sv
// ----------------------------------------------------------------------------
// stws_pkg: shared types and constants for the telemetry sender
// Action codes, sender state codes, fixed field widths and the control
// structs that pass between the sequencer and the chunk gather unit.
// ----------------------------------------------------------------------------
package stws_pkg;

    // Input actions
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_TAKE    = 2'd2;
    localparam logic [1:0] ACT_CONFIRM = 2'd3;

    // Sender states, as reported on sender_state
    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_SENDING     = 3'd1;
    localparam logic [2:0] ST_RESYNC      = 3'd2;
    localparam logic [2:0] ST_RESYNC_SEND = 3'd3;
    localparam logic [2:0] ST_WAIT_FINAL  = 3'd4;

    // Fixed widths of the result fields
    localparam int PAYLOAD_BYTES = 5;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int CNT_W         = 4;   // holds a chunk size up to 15
    localparam int SLOT_W        = 3;   // byte slot within a chunk

    // Reset value of the miss limit
    localparam logic [15:0] WAIT_RESET = 16'd80;

    // Request to the gather unit
    typedef struct packed {
        logic             start;
        logic [7:0]       base;
        logic [CNT_W-1:0] count;
    } stws_gather_req_t;

    // Status from the gather unit
    typedef struct packed {
        logic busy;
        logic done;
    } stws_gather_sts_t;

endpackage

FILE: hdl/stws_ram.sv
// ----------------------------------------------------------------------------
// stws_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/stws_gather.sv
// ----------------------------------------------------------------------------
// stws_gather: chunk byte gather unit
// Reads one buffer byte per cycle through the single RAM read port and
// packs the bytes of a chunk into the payload word, first byte lowest.
// ----------------------------------------------------------------------------
module stws_gather
    import stws_pkg::*;
#(
    parameter int MESSAGE_BYTES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stws_gather_req_t                 req,
    output stws_gather_sts_t                 sts,
    output logic                             ram_re,
    output logic [$clog2(MESSAGE_BYTES)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata,
    output logic [PAYLOAD_W-1:0]             payload
);

    localparam int AW = $clog2(MESSAGE_BYTES);

    logic                 busy_reg, busy_next;
    logic [7:0]           base_reg, base_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 zero_reg, zero_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [8:0]           pos;
    logic                 in_range;
    logic [7:0]           rd_byte;
    logic                 done;

    assign pos      = {1'b0, base_reg} + 9'(issue_reg);
    assign in_range = pos < 9'(MESSAGE_BYTES);
    assign rd_byte  = zero_reg ? 8'd0 : ram_rdata;

    // Issue one read per cycle, place the byte returned from the last one
    always_comb
    begin
        busy_next    = busy_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        slot_next    = slot_reg;
        zero_next    = zero_reg;
        payload_next = payload_reg;
        ram_re       = 1'b0;
        ram_raddr    = pos[AW-1:0];
        done         = 1'b0;

        if (pend_reg)
        begin
            for (int j = 0; j < PAYLOAD_BYTES; j++)
            begin
                if (slot_reg == SLOT_W'(j))
                begin
                    payload_next[j*8 +: 8] = rd_byte;
                end
            end
        end

        if (req.start)
        begin
            busy_next    = 1'b1;
            base_next    = req.base;
            cnt_next     = req.count;
            issue_next   = '0;
            payload_next = '0;
        end
        else if (busy_reg)
        begin
            if (issue_reg < cnt_reg)
            begin
                ram_re     = in_range;
                pend_next  = 1'b1;
                slot_next  = issue_reg[SLOT_W-1:0];
                zero_next  = !in_range;
                issue_next = issue_reg + CNT_W'(1);
            end
            else if (!pend_reg)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        cnt_reg     <= cnt_next;
        issue_reg   <= issue_next;
        slot_reg    <= slot_next;
        zero_reg    <= zero_next;
        payload_reg <= payload_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done;
    assign payload  = payload_reg;

endmodule

FILE: hdl/stubborn_telemetry_sender_core.sv
// ----------------------------------------------------------------------------
// stubborn_telemetry_sender_core: chunked telemetry sender, alternating bit
// Buffers a message and hands it out in chunks, tracking confirm bits,
// misses and resync.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per action: write a
//   buffer byte, start a message, take a chunk or deliver a confirm bit.
//   Every accepted word yields exactly one result word on the output
//   channel (out_valid/out_ready).
//   Write, start and confirm pass from accept into the hold state, then into
//   the output register. A take chunk reads its n bytes (at most CHUNK_BYTES)
//   one per cycle from the single buffer RAM read port, then waits in the
//   hold state the same way. The next word can be accepted, at the earliest,
//   in the cycle after the result moves into the output register.
//   in_ready is high only while the sequencer is idle; the next word may be
//   accepted while the previous result still waits in the output register.
//   If the receiver stalls, the finished result is held in the sequencer
//   until the output register frees up, and in_ready stays low meanwhile.
//   cfg_we/cfg_wdata write the miss limit (reset 80).
//   Reset: sender idle, package number 1, expected confirm 1, no misses.
//   Buffer contents are not cleared; read only bytes that were written.
// ----------------------------------------------------------------------------
module stubborn_telemetry_sender_core
    import stws_pkg::*;
#(
    parameter int CHUNK_BYTES   = 5,
    parameter int RESYNC_INDEX  = 63,
    parameter int MESSAGE_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [7:0]           byte_index,
    input  logic [7:0]           byte_value,
    input  logic [7:0]           message_length,
    input  logic                 confirm_bit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           package_index,
    output logic [PAYLOAD_W-1:0] payload_bytes,
    output logic [2:0]           byte_count,
    output logic                 active,
    output logic [2:0]           sender_state,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);

    localparam int AW = $clog2(MESSAGE_BYTES);

    // Sequencer states
    localparam logic [1:0] SQ_IDLE   = 2'd0;
    localparam logic [1:0] SQ_GATHER = 2'd1;
    localparam logic [1:0] SQ_HOLD   = 2'd2;

    logic [1:0]       seq_reg, seq_next;
    logic [2:0]       st_reg, st_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       off_reg, off_next;
    logic [7:0]       pkg_reg, pkg_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic             exp_reg, exp_next;
    logic [15:0]      miss_reg, miss_next;
    logic [15:0]      wait_max_reg;

    // Pending result
    logic [5:0]       pidx_reg, pidx_next;
    logic [2:0]       pcnt_reg, pcnt_next;
    logic [2:0]       pst_reg, pst_next;
    logic             ptake_reg, ptake_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [5:0]           oidx_reg;
    logic [PAYLOAD_W-1:0] opay_reg;
    logic [2:0]           ocnt_reg;
    logic [2:0]           ost_reg;
    logic                 load_out;

    logic             in_acc;
    logic [7:0]       left;
    logic [CNT_W-1:0] n;
    logic [8:0]       end_pos;
    logic [7:0]       off_adv;
    logic [15:0]      miss_inc;
    logic             miss_over;

    stws_gather_req_t     greq;
    stws_gather_sts_t     gsts;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [7:0]           ram_rdata;
    logic [PAYLOAD_W-1:0] gpayload;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (seq_reg == SQ_IDLE);
    assign left      = len_reg - off_reg;
    assign n         = (left < 8'(CHUNK_BYTES)) ? left[CNT_W-1:0] : CNT_W'(CHUNK_BYTES);
    assign end_pos   = {1'b0, off_reg} + 9'(n);
    assign off_adv   = off_reg + 8'(last_reg);
    assign miss_inc  = miss_reg + 16'd1;
    assign miss_over = miss_inc > wait_max_reg;
    assign ram_we    = in_acc && (action == ACT_WRITE)
                       && ({1'b0, byte_index} < 9'(MESSAGE_BYTES));
    assign load_out  = (seq_reg == SQ_HOLD) && (!out_valid_reg || out_ready);

    // Protocol state update and sequencer
    always_comb
    begin
        seq_next   = seq_reg;
        st_next    = st_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        pkg_next   = pkg_reg;
        last_next  = last_reg;
        exp_next   = exp_reg;
        miss_next  = miss_reg;
        pidx_next  = pidx_reg;
        pcnt_next  = pcnt_reg;
        pst_next   = pst_reg;
        ptake_next = ptake_reg;
        greq       = '0;
        greq.base  = off_reg;
        greq.count = n;

        if (in_acc)
        begin
            pidx_next  = '0;
            pcnt_next  = '0;
            ptake_next = 1'b0;
            case (action)
                ACT_WRITE:
                begin
                    seq_next = SQ_HOLD;
                end
                ACT_START:
                begin
                    len_next  = message_length;
                    off_next  = '0;
                    pkg_next  = 8'd1;
                    miss_next = '0;
                    st_next   = (st_reg == ST_IDLE) ? ST_SENDING : ST_RESYNC_SEND;
                    seq_next  = SQ_HOLD;
                end
                ACT_TAKE:
                begin
                    last_next  = '0;
                    ptake_next = 1'b1;
                    greq.count = '0;
                    if (st_reg == ST_RESYNC || st_reg == ST_RESYNC_SEND)
                    begin
                        pidx_next = RESYNC_INDEX[5:0];
                    end
                    else if (st_reg == ST_SENDING)
                    begin
                        last_next  = n;
                        pcnt_next  = n[2:0];
                        greq.count = n;
                        if (pkg_reg > 8'd1 && end_pos >= {1'b0, len_reg})
                        begin
                            pidx_next = '0;
                        end
                        else
                        begin
                            pidx_next = pkg_reg[5:0];
                        end
                    end
                    greq.start = 1'b1;
                    seq_next   = SQ_GATHER;
                end
                default:
                begin
                    // Confirm
                    seq_next = SQ_HOLD;
                    case (st_reg)
                        ST_SENDING:
                        begin
                            if (confirm_bit != exp_reg)
                            begin
                                miss_next = miss_inc;
                                if (miss_over)
                                begin
                                    exp_next = !confirm_bit;
                                    st_next  = ST_RESYNC;
                                end
                            end
                            else
                            begin
                                off_next = off_adv;
                                if (off_adv >= len_reg)
                                begin
                                    st_next = (pkg_reg == 8'd1) ? ST_WAIT_FINAL : ST_IDLE;
                                end
                                pkg_next  = pkg_reg + 8'd1;
                                exp_next  = !exp_reg;
                                miss_next = '0;
                            end
                        end
                        ST_RESYNC, ST_RESYNC_SEND, ST_WAIT_FINAL:
                        begin
                            if (confirm_bit == exp_reg)
                            begin
                                st_next  = (st_reg == ST_RESYNC_SEND) ? ST_SENDING : ST_IDLE;
                                exp_next = !confirm_bit;
                            end
                            else if (st_reg == ST_WAIT_FINAL)
                            begin
                                miss_next = miss_inc;
                                if (miss_over)
                                begin
                                    exp_next = !confirm_bit;
                                    st_next  = ST_RESYNC;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
            pst_next = st_next;
        end
        else
        begin
            case (seq_reg)
                SQ_GATHER:
                begin
                    if (gsts.done)
                    begin
                        seq_next = SQ_HOLD;
                    end
                end
                SQ_HOLD:
                begin
                    if (load_out)
                    begin
                        seq_next = SQ_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and protocol state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            st_reg        <= ST_IDLE;
            len_reg       <= '0;
            off_reg       <= '0;
            pkg_reg       <= 8'd1;
            last_reg      <= '0;
            exp_reg       <= 1'b1;
            miss_reg      <= '0;
            wait_max_reg  <= WAIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            st_reg        <= st_next;
            len_reg       <= len_next;
            off_reg       <= off_next;
            pkg_reg       <= pkg_next;
            last_reg      <= last_next;
            exp_reg       <= exp_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                wait_max_reg <= cfg_wdata;
            end
        end
    end

    // Pending result and output payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        pcnt_reg  <= pcnt_next;
        pst_reg   <= pst_next;
        ptake_reg <= ptake_next;
        if (load_out)
        begin
            oidx_reg <= pidx_reg;
            opay_reg <= ptake_reg ? gpayload : '0;
            ocnt_reg <= pcnt_reg;
            ost_reg  <= pst_reg;
        end
    end

    // Message buffer
    stws_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_index[AW-1:0]),
        .wdata (byte_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Chunk gather unit
    stws_gather #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (greq),
        .sts       (gsts),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .payload   (gpayload)
    );

    assign out_valid     = out_valid_reg;
    assign package_index = oidx_reg;
    assign payload_bytes = opay_reg;
    assign byte_count    = ocnt_reg;
    assign active        = (ost_reg != ST_IDLE);
    assign sender_state  = ost_reg;

    // The gather unit only runs while the sequencer holds off new words
    a_gather_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !gsts.busy)
        else $error("gather unit busy while input is open");

    // A taken chunk closes the input for at least the next cycle
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == ACT_TAKE) |=> !in_ready)
        else $error("input open right after a take chunk");

    // Payload bytes only come out of the sending state
    a_bytes_when_sending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count != 3'd0) |-> (sender_state == ST_SENDING))
        else $error("chunk bytes reported outside sending state");

    // Gather completion only happens while the sequencer waits for it
    a_done_in_gather: assert property (@(posedge clk) disable iff (!rst_n)
        gsts.done |-> (seq_reg == SQ_GATHER))
        else $error("gather done outside gather phase");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the chunked telemetry sender core
// Drives write, start, take and confirm words over a valid/ready channel with
// random idling on both sides, shadows the sender state in a small class and
// compares every result word field by field. The miss limit is changed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import stws_pkg::*;

    localparam int CHUNK_BYTES    = 5;
    localparam int RESYNC_INDEX   = 63;
    localparam int MESSAGE_BYTES  = 256;
    localparam int PHASE_WORDS    = 225;
    localparam int NUM_PHASES     = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    // Miss limits for phases after the first, which runs on the reset value
    localparam logic [15:0] LIMIT_PLAN [0:6] =
        '{16'd0, 16'd65534, 16'd1, 16'd3, 16'd80, 16'd0, 16'd2};

    typedef struct packed {
        logic [5:0]           package_index;
        logic [PAYLOAD_W-1:0] payload;
        logic [2:0]           byte_count;
        logic                 active;
        logic [2:0]           state;
    } chunk_result_t;

    // ------------------------------------------------------------------------
    // Shadow of the sender: predicts one result per word, holds the results
    // still outstanding and checks arriving ones against them
    // ------------------------------------------------------------------------
    class sender_shadow;
        bit [7:0]      mem [MESSAGE_BYTES];
        bit            written [MESSAGE_BYTES];
        bit [2:0]      send_st = ST_IDLE;
        bit [7:0]      msg_len = 8'd0;
        bit [7:0]      offset = 8'd0;
        bit [7:0]      pkg_num = 8'd1;
        bit [3:0]      last_cnt = 4'd0;
        bit            want_bit = 1'b1;
        bit [15:0]     misses = 16'd0;
        bit [15:0]     wait_limit = WAIT_RESET;
        chunk_result_t pending_results [$];
        int            errors = 0;
        int            checked = 0;
        int            resyncs = 0;

        // Bytes the next chunk carries while sending
        function int chunk_size();
            bit [7:0] left;
            left = msg_len - offset;
            return (int'(left) < CHUNK_BYTES) ? int'(left) : CHUNK_BYTES;
        endfunction

        // First unwritten buffer byte the next chunk would read, or -1
        function int first_gap();
            int n;
            int pos;
            if (send_st != ST_SENDING)
                return -1;
            n = chunk_size();
            for (int i = 0; i < n; i++)
            begin
                pos = int'(offset) + i;
                if (pos < MESSAGE_BYTES && !written[pos])
                    return pos;
            end
            return -1;
        endfunction

        function void note_miss(bit cbit);
            misses = misses + 16'd1;
            if (misses > wait_limit)
            begin
                want_bit = cbit ^ 1'b1;
                send_st = ST_RESYNC;
                resyncs++;
            end
        endfunction

        function void predict_take(ref chunk_result_t r);
            int n;
            int pos;
            last_cnt = 4'd0;
            if (send_st == ST_RESYNC || send_st == ST_RESYNC_SEND)
                r.package_index = 6'(RESYNC_INDEX);
            else if (send_st == ST_SENDING)
            begin
                n = chunk_size();
                last_cnt = 4'(n);
                if (pkg_num > 8'd1 && int'(offset) + n >= int'(msg_len))
                    r.package_index = 6'd0;
                else
                    r.package_index = pkg_num[5:0];
                for (int i = 0; i < n; i++)
                begin
                    pos = int'(offset) + i;
                    if (pos < MESSAGE_BYTES)
                        r.payload[8*i +: 8] = mem[pos];
                end
            end
            r.byte_count = last_cnt[2:0];
        endfunction

        function void predict_confirm(bit cbit);
            case (send_st)
                ST_SENDING:
                begin
                    if (cbit != want_bit)
                        note_miss(cbit);
                    else
                    begin
                        offset = offset + 8'(last_cnt);
                        if (offset >= msg_len)
                            send_st = (pkg_num == 8'd1) ? ST_WAIT_FINAL : ST_IDLE;
                        pkg_num = pkg_num + 8'd1;
                        want_bit = want_bit ^ 1'b1;
                        misses = 16'd0;
                    end
                end
                ST_RESYNC, ST_RESYNC_SEND, ST_WAIT_FINAL:
                begin
                    if (cbit == want_bit)
                    begin
                        send_st = (send_st == ST_RESYNC_SEND) ? ST_SENDING : ST_IDLE;
                        want_bit = cbit ^ 1'b1;
                    end
                    else if (send_st == ST_WAIT_FINAL)
                        note_miss(cbit);
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted word and queue its expected result
        function void accept_word(logic [1:0] act, logic [7:0] bidx, logic [7:0] bval,
                                  logic [7:0] mlen, logic cbit);
            chunk_result_t r;
            r = '0;
            case (act)
                ACT_WRITE:
                begin
                    mem[bidx] = bval;
                    written[bidx] = 1'b1;
                end
                ACT_START:
                begin
                    msg_len = mlen;
                    offset = 8'd0;
                    pkg_num = 8'd1;
                    misses = 16'd0;
                    send_st = (send_st == ST_IDLE) ? ST_SENDING : ST_RESYNC_SEND;
                end
                ACT_TAKE: predict_take(r);
                default: predict_confirm(cbit);
            endcase
            r.active = (send_st != ST_IDLE);
            r.state = send_st;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [5:0] pidx, logic [PAYLOAD_W-1:0] pay,
                                   logic [2:0] cnt, logic act, logic [2:0] st);
            chunk_result_t e;
            checked++;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing outstanding: package_index %0d state %0d",
                       pidx, st);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (pidx !== e.package_index)
            begin
                $error("package_index: expected %0d, got %0d", e.package_index, pidx);
                errors++;
            end
            if (pay !== e.payload)
            begin
                $error("payload_bytes: expected %h, got %h", e.payload, pay);
                errors++;
            end
            if (cnt !== e.byte_count)
            begin
                $error("byte_count: expected %0d, got %0d", e.byte_count, cnt);
                errors++;
            end
            if (act !== e.active)
            begin
                $error("active: expected %0d, got %0d", e.active, act);
                errors++;
            end
            if (st !== e.state)
            begin
                $error("sender_state: expected %0d, got %0d", e.state, st);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           action = ACT_WRITE;
    logic [7:0]           byte_index = 8'd0;
    logic [7:0]           byte_value = 8'd0;
    logic [7:0]           message_length = 8'd0;
    logic                 confirm_bit = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [5:0]           package_index;
    logic [PAYLOAD_W-1:0] payload_bytes;
    logic [2:0]           byte_count;
    logic                 active;
    logic [2:0]           sender_state;
    logic                 cfg_we = 1'b0;
    logic [15:0]          cfg_wdata = 16'd0;

    sender_shadow shadow;
    int           words_sent = 0;
    bit           send_calm = 1'b0;
    int           quiet_cycles = 0;

    stubborn_telemetry_sender_core #(
        .CHUNK_BYTES   (CHUNK_BYTES),
        .RESYNC_INDEX  (RESYNC_INDEX),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .message_length (message_length),
        .confirm_bit    (confirm_bit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .package_index  (package_index),
        .payload_bytes  (payload_bytes),
        .byte_count     (byte_count),
        .active         (active),
        .sender_state   (sender_state),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Watchdog: give up after a long stretch with no word moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one word after a random gap and return at the accepting edge.
    // A take that would read an unwritten byte becomes a write of that byte.
    task automatic issue(logic [1:0] act, logic [7:0] bidx, logic [7:0] bval,
                         logic [7:0] mlen, logic cbit);
        int gap;
        int hole;
        hole = shadow.first_gap();
        if (act == ACT_TAKE && hole >= 0)
        begin
            act = ACT_WRITE;
            bidx = 8'(hole);
        end
        if (words_sent % 40 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        byte_index     <= bidx;
        byte_value     <= bval;
        message_length <= mlen;
        confirm_bit    <= cbit;
        do @(posedge clk); while (!in_ready);
        shadow.accept_word(act, bidx, bval, mlen, cbit);
        words_sent++;
    endtask

    task automatic post_byte(logic [7:0] pos, logic [7:0] val);
        issue(ACT_WRITE, pos, val, 8'($urandom), 1'($urandom));
    endtask

    task automatic begin_message(logic [7:0] len);
        issue(ACT_START, 8'($urandom), 8'($urandom), len, 1'($urandom));
    endtask

    task automatic take_chunk();
        issue(ACT_TAKE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_confirm(logic cbit);
        issue(ACT_CONFIRM, 8'($urandom), 8'($urandom), 8'($urandom), cbit);
    endtask

    task automatic wait_all_results();
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Change the miss limit once the core has drained
    task automatic set_wait_limit(logic [15:0] limit);
        in_valid <= 1'b0;
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.wait_limit = limit;
    endtask

    // One message: stage some bytes, start, then take and confirm until the
    // sender goes idle or 200 steps pass, with wrong bits, blind confirms and restarts mixed in
    task automatic send_message();
        int  len;
        int  roll;
        int  steps;
        int  storm;
        bit  pump;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        // Blind confirms after an empty take push the package number around
        pump = (shadow.send_st == ST_IDLE) && ($urandom_range(0, 7) == 0);
        if (pump)
        begin
            take_chunk();
            len = $urandom_range(6, 40);
        end
        if (len > 0)
            repeat ($urandom_range(0, 6))
                post_byte(8'($urandom_range(0, len - 1)), 8'($urandom));
        begin_message(8'(len));
        if (pump)
            repeat ($urandom_range(60, 260))
                send_confirm(shadow.want_bit);
        // Run of wrong bits, enough to cross a small miss limit
        if ($urandom_range(0, 5) == 0)
        begin
            storm = int'(shadow.wait_limit) + 1 + $urandom_range(0, 1);
            if (storm > 90)
                storm = 90;
            repeat (storm) send_confirm(~shadow.want_bit);
        end
        steps = 0;
        while (shadow.send_st != ST_IDLE && steps < 200)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                begin_message(8'($urandom_range(0, 30)));
            else if (roll < 10)
                send_confirm(~shadow.want_bit);
            else
            begin
                if (roll >= 15)
                    take_chunk();
                send_confirm(shadow.want_bit);
            end
            steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, calm stretches and one long hold
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (taken == 400)
                stall = LONG_HOLD;
            else
                stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            shadow.check_result(package_index, payload_bytes, byte_count, active,
                                sender_state);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_end;
        shadow = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle sender: nothing to take, confirms have no effect
        take_chunk();
        send_confirm(1'b0);
        // Buffer extremes and a short message body
        post_byte(8'd0, 8'h00);
        post_byte(8'd255, 8'hFF);
        post_byte(8'd1, 8'hA5);
        post_byte(8'd2, 8'h5A);
        post_byte(8'd3, 8'h3C);
        post_byte(8'd4, 8'hC3);
        post_byte(8'd5, 8'h81);
        // Empty message, then the blank final slot with one miss
        begin_message(8'd0);
        take_chunk();
        send_confirm(shadow.want_bit);
        take_chunk();
        send_confirm(~shadow.want_bit);
        send_confirm(shadow.want_bit);
        // Two chunks: full chunk then the final short one
        begin_message(8'd6);
        take_chunk();
        send_confirm(shadow.want_bit);
        take_chunk();
        send_confirm(shadow.want_bit);
        // Restart while busy goes through resync first
        begin_message(8'd3);
        begin_message(8'd3);
        take_chunk();
        send_confirm(shadow.want_bit);

        // Random phases, each with its own miss limit
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                set_wait_limit(LIMIT_PLAN[p-1]);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 8))
                        issue(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom));
                else
                    send_message();
            end
        end
        in_valid <= 1'b0;
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d words over %0d miss-limit settings (0 to 65534).",
                 words_sent, NUM_PHASES);
        $display("Checked %0d result words; %0d resyncs forced by misses.",
                 shadow.checked, shadow.resyncs);
        if (shadow.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
hdl/stws_pkg.sv
hdl/stws_ram.sv
hdl/stws_gather.sv
hdl/stubborn_telemetry_sender_core.sv
tb/tb_top.sv
